[rtl/glc_pkg.sv]
// shared types and constants for the glyph class lookup unit
`timescale 1ns / 1ps
`default_nettype none

package glc_pkg;

   localparam int GLYPH_W = 16;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int FMT_W   = 2;
   localparam int CSR_IDX_W = 2;

   // command codes carried in req_tuser
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // table formats
   localparam logic [FMT_W-1:0] FMT_ARRAY  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RANGES = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_GLYPH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_COUNT = 2'd3;

   typedef struct packed {
      logic [GLYPH_W-1:0] first;
      logic [GLYPH_W-1:0] last;
      logic [GLYPH_W-1:0] cls;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic mem_write;
      logic f1_read;
      logic srch_init;
      logic probe_read;
      logic srch_update;
      logic res_zero;
      logic res_from_mem;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic fmt_array;
      logic fmt_ranges;
      logic f1_hit;
      logic search_open;
      logic probe_hit;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/glc_datapath.sv]
// datapath: request and config registers, entry table, search bounds, result buffer
`timescale 1ns / 1ps
`default_nettype none

module glc_datapath #(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire glc_pkg::cmd_type                      cmd,
   output wire glc_pkg::status_type                   sts,
   input  wire logic                                  req_tuser,
   input  wire logic [79:0]                           req_tdata,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [glc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [glc_pkg::GLYPH_W-1:0]           csr_data,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [glc_pkg::GLYPH_W-1:0]                rsp_tdata
);
   import glc_pkg::*;

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SRCH_W = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;
   localparam int WIDE_W = GLYPH_W + 1;
   localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_ENTRIES);
   localparam logic [SRCH_W-1:0] MAX_SRCH = SRCH_W'(MAX_ENTRIES);

   entry_type table_mem [MAX_ENTRIES];

   logic                 cmd_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [GLYPH_W-1:0]   first_ff, last_ff, class_ff, gid_ff;

   logic [FMT_W-1:0]     fmt_ff;
   logic [GLYPH_W-1:0]   first_glyph_ff;
   logic [COUNT_W-1:0]   glyph_count_ff, range_count_ff;

   logic [SRCH_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid;
   logic [SRCH_W:0]      mid_sum;
   logic [SRCH_W-1:0]    range_clamp;
   entry_type            rdata_ff;
   logic [GLYPH_W-1:0]   res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0]   rsp_data_ff;

   logic [WIDE_W-1:0]    f1_end;
   logic [GLYPH_W-1:0]   f1_off;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic                 wr_ok;

   assign csr_ready = 1'b1;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_tuser;
         idx_ff   <= req_tdata[9:0];
         first_ff <= req_tdata[25:10];
         last_ff  <= req_tdata[41:26];
         class_ff <= req_tdata[57:42];
         gid_ff   <= req_tdata[73:58];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff         <= FMT_ARRAY;
         first_glyph_ff <= '0;
         glyph_count_ff <= '0;
         range_count_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FORMAT:      fmt_ff         <= csr_data[FMT_W-1:0];
            REG_FIRST_GLYPH: first_glyph_ff <= csr_data;
            REG_GLYPH_COUNT: glyph_count_ff <= csr_data[COUNT_W-1:0];
            REG_RANGE_COUNT: range_count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // format 1 coverage, range end formed without wrap
   assign f1_end = {1'b0, first_glyph_ff} + WIDE_W'(glyph_count_ff);
   assign f1_off = gid_ff - first_glyph_ff;

   // format 2 search bounds
   assign range_clamp = (SRCH_W'(range_count_ff) > MAX_SRCH) ? MAX_SRCH
                                                            : SRCH_W'(range_count_ff);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[SRCH_W:1];

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = range_clamp;
      end else if (cmd.srch_update) begin
         if (rdata_ff.last < gid_ff) begin
            lo_in = mid_ff + SRCH_W'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.probe_read) begin
         mid_ff <= mid;
      end
   end

   // entry table, one write and one registered read port
   assign wr_addr = ADDR_W'(idx_ff);
   assign wr_ok   = {{(WIDE_W-INDEX_W){1'b0}}, idx_ff} < MAX_WIDE;
   assign rd_addr = cmd.f1_read ? ADDR_W'(f1_off) : mid[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_ok) begin
         table_mem[wr_addr] <= '{first: first_ff, last: last_ff, cls: class_ff};
      end
      if (cmd.f1_read || cmd.probe_read) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // result and output buffer
   always_comb begin
      res_in = res_ff;
      if (cmd.res_zero) begin
         res_in = '0;
      end else if (cmd.res_from_mem) begin
         res_in = rdata_ff.cls;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.is_write    = (cmd_ff == CMD_WRITE);
   assign sts.fmt_array   = (fmt_ff == FMT_ARRAY);
   assign sts.fmt_ranges  = (fmt_ff == FMT_RANGES);
   assign sts.f1_hit      = ({1'b0, gid_ff} >= {1'b0, first_glyph_ff}) &&
                            ({1'b0, gid_ff} < f1_end) &&
                            ({1'b0, f1_off} < MAX_WIDE);
   assign sts.search_open = (lo_ff < hi_ff);
   assign sts.probe_hit   = (rdata_ff.first <= gid_ff) && (gid_ff <= rdata_ff.last);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

[rtl/glc_controller.sv]
// controller: sequences table writes, array lookups and the range search
`timescale 1ns / 1ps
`default_nettype none

module glc_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire glc_pkg::status_type sts,
   output glc_pkg::cmd_type         cmd
);
   import glc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_F1WAIT = 3'd2;
   localparam logic [2:0] ST_PROBE  = 3'd3;
   localparam logic [2:0] ST_CMP    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.is_write) begin
               cmd.mem_write = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.fmt_array) begin
               if (sts.f1_hit) begin
                  cmd.f1_read = 1'b1;
                  state_in    = ST_F1WAIT;
               end else begin
                  cmd.res_zero = 1'b1;
                  state_in     = ST_DONE;
               end
            end else if (sts.fmt_ranges) begin
               cmd.srch_init = 1'b1;
               state_in      = ST_PROBE;
            end else begin
               cmd.res_zero = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_F1WAIT: begin
            cmd.res_from_mem = 1'b1;
            state_in         = ST_DONE;
         end
         ST_PROBE: begin
            if (sts.search_open) begin
               cmd.probe_read = 1'b1;
               state_in       = ST_CMP;
            end else begin
               cmd.res_zero = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_CMP: begin
            if (sts.probe_hit) begin
               cmd.res_from_mem = 1'b1;
               state_in         = ST_DONE;
            end else begin
               cmd.srch_update = 1'b1;
               state_in        = ST_PROBE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a captured beat is always decoded next
   a_load_then_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == ST_DECIDE)
      else $error("request not decoded after capture");

   // every probe read is compared on the following cycle
   a_probe_then_cmp: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_read |=> state_ff == ST_CMP && !cmd.probe_read)
      else $error("probe read not followed by compare");

   // the output buffer is never overwritten while a result waits
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded into a full output buffer");

   // the entry table sees at most one access (write, array read or probe read) a cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mem_write, cmd.f1_read, cmd.probe_read}))
      else $error("table port accessed twice in one cycle");

endmodule

`default_nettype wire

[rtl/glyph_class_lookup_unit.sv]
// glyph class lookup unit: top level joining controller and datapath
// A beat on req_ with tuser 0 writes one table entry (first, last, class) and gives no
// response; tuser 1 looks up a glyph and gives one rsp_ beat with its class, 0 on a miss.
// One item is in work at a time. A write is stored in the decode state, and the next beat
// can be taken back in idle. A format 1 hit reads the table in decode and takes the class
// in the wait state; an array miss or a lookup in format 0 or 3 goes from decode to done.
// A format 2 lookup alternates probe and compare states, up to 11 probes with 1024 ranges,
// and ends on a hit in compare or an empty search in probe; each probe is a registered
// read of the entry table. Done loads the result into an output register once it is free,
// and the next request can be taken in the same cycle that it appears, while it waits.
// Configuration writes on csr_ are taken every cycle and belong between items only.
`timescale 1ns / 1ps
`default_nettype none

module glyph_class_lookup_unit #(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // entry_index[9:0], range_first[25:10], range_last[41:26], entry_class[57:42],
   // glyph_id[73:58], zero fill[79:74]
   input  wire logic [79:0]                   req_tdata,
   // command[0]
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // class_value[15:0]
   output logic [glc_pkg::GLYPH_W-1:0]        rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [glc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [glc_pkg::GLYPH_W-1:0]   csr_data
);
   import glc_pkg::*;

   cmd_type    cmd;
   status_type sts;

   glc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   glc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
